### hw/rtl/qnlerp_pkg.sv
package qnlerp_pkg;

  // Component width of the input quaternions
  localparam int CompBits = 16;
  // Output component width, Q2.14
  localparam int OutBits = 16;
  // Blend weight width, Q1.14
  localparam int AlphaBits = 15;
  localparam int Q14One = 16384;

  // Width of a component entering the normalizer (holds the exact blend)
  localparam int NormW = 30;
  // Sum of four squares and its square root
  localparam int SumW = 2 * NormW + 2;
  localparam int RootW = NormW + 1;
  localparam int SqrtSteps = RootW;
  // Quotient bits of round(|c| * 2^14 / n), at most 16384
  localparam int DivSteps = 15;
  localparam int NumW = NormW + 15;

  // Normalizer: 6 front stages, root steps, divide setup, divide steps, output
  localparam int NormLat = 6 + SqrtSteps + 1 + DivSteps + 1;
  // Input register, two normalizer passes and four blend stages
  localparam int TotLat = 2 * NormLat + 5;

  typedef logic signed [NormW-1:0] norm_in_t;
  typedef logic signed [OutBits-1:0] comp_t;

endpackage

### hw/rtl/qnlerp_norm.sv
module qnlerp_norm (
  input  logic                 clk,
  input  logic                 ce,
  input  qnlerp_pkg::norm_in_t in_c [4],
  output qnlerp_pkg::comp_t    out_c [4],
  output logic                 fallback
);

  typedef struct packed {
    logic [33:0]                                rem;
    logic [qnlerp_pkg::RootW-1:0]               root;
    logic [qnlerp_pkg::SumW-1:0]                val;
    logic [3:0][qnlerp_pkg::NormW-1:0]          mag;
    logic [3:0]                                 neg;
    logic                                       zero;
  } sq_st_t;

  typedef struct packed {
    logic [3:0][qnlerp_pkg::NumW-1:0]           rem;
    logic [3:0][qnlerp_pkg::DivSteps-1:0]       quo;
    logic [qnlerp_pkg::RootW-1:0]               n;
    logic [3:0]                                 neg;
    logic                                       zero;
  } dv_st_t;

  logic [qnlerp_pkg::NormW-1:0]     s1_mag [4];
  logic [3:0]                       s1_neg;
  logic [qnlerp_pkg::NormW-1:0]     s2_mag [4];
  logic [3:0]                       s2_neg;
  logic [4:0]                       s2_sh;
  logic                             s2_zero;
  logic [qnlerp_pkg::NormW-1:0]     s3_mag [4];
  logic [3:0]                       s3_neg;
  logic                             s3_zero;
  logic [2*qnlerp_pkg::NormW-1:0]   s4_sq [4];
  logic [qnlerp_pkg::NormW-1:0]     s4_mag [4];
  logic [3:0]                       s4_neg;
  logic                             s4_zero;
  logic [2*qnlerp_pkg::NormW:0]     s5_sa;
  logic [2*qnlerp_pkg::NormW:0]     s5_sb;
  logic [qnlerp_pkg::NormW-1:0]     s5_mag [4];
  logic [3:0]                       s5_neg;
  logic                             s5_zero;
  sq_st_t                           s6;
  sq_st_t                           sq [qnlerp_pkg::SqrtSteps];
  dv_st_t                           dv0;
  dv_st_t                           dv [qnlerp_pkg::DivSteps];

  logic [qnlerp_pkg::NormW-1:0]     or_mag;
  logic [4:0]                       sh;

  // Split into sign and magnitude
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        s1_neg[k] <= in_c[k][qnlerp_pkg::NormW-1];
        s1_mag[k] <= in_c[k][qnlerp_pkg::NormW-1] ? qnlerp_pkg::NormW'(-in_c[k])
                                                    : qnlerp_pkg::NormW'(in_c[k]);
      end
    end
  end

  // Find the shift that brings the largest magnitude to the top bit
  always_comb begin
    or_mag = s1_mag[0] | s1_mag[1] | s1_mag[2] | s1_mag[3];
    sh = '0;
    for (int i = 0; i < qnlerp_pkg::NormW; i++) begin
      if (or_mag[i]) sh = 5'(qnlerp_pkg::NormW - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_mag  <= s1_mag;
      s2_neg  <= s1_neg;
      s2_sh   <= sh;
      s2_zero <= (or_mag == '0);
    end
  end

  // Normalize, then square
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) s3_mag[k] <= s2_mag[k] << s2_sh;
      s3_neg  <= s2_neg;
      s3_zero <= s2_zero;
      for (int k = 0; k < 4; k++) begin
        s4_sq[k] <= (2*qnlerp_pkg::NormW)'(s3_mag[k]) * (2*qnlerp_pkg::NormW)'(s3_mag[k]);
      end
      s4_mag  <= s3_mag;
      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
    end
  end

  // Sum of squares over two stages
  always_ff @(posedge clk) begin
    if (ce) begin
      s5_sa   <= (2*qnlerp_pkg::NormW+1)'(s4_sq[0]) + (2*qnlerp_pkg::NormW+1)'(s4_sq[1]);
      s5_sb   <= (2*qnlerp_pkg::NormW+1)'(s4_sq[2]) + (2*qnlerp_pkg::NormW+1)'(s4_sq[3]);
      s5_mag  <= s4_mag;
      s5_neg  <= s4_neg;
      s5_zero <= s4_zero;
      s6.rem  <= '0;
      s6.root <= '0;
      s6.val  <= qnlerp_pkg::SumW'(s5_sa) + qnlerp_pkg::SumW'(s5_sb);
      for (int k = 0; k < 4; k++) s6.mag[k] <= s5_mag[k];
      s6.neg  <= s5_neg;
      s6.zero <= s5_zero;
    end
  end

  // Square root, one result bit per stage
  for (genvar g = 0; g < qnlerp_pkg::SqrtSteps; g++) begin : g_sqrt
    sq_st_t      src;
    sq_st_t      nxt;
    logic [35:0] rem2;
    logic [35:0] trial;

    if (g == 0) begin : g_first
      assign src = s6;
    end else begin : g_rest
      assign src = sq[g-1];
    end

    always_comb begin
      nxt   = src;
      rem2  = {src.rem, src.val[qnlerp_pkg::SumW-1 -: 2]};
      trial = {3'b000, src.root, 2'b01};
      nxt.val = {src.val[qnlerp_pkg::SumW-3:0], 2'b00};
      if (rem2 >= trial) begin
        nxt.rem  = 34'(rem2 - trial);
        nxt.root = {src.root[qnlerp_pkg::RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = rem2[33:0];
        nxt.root = {src.root[qnlerp_pkg::RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (ce) sq[g] <= nxt;
    end
  end

  // Set up dividends with the rounding term n/2
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        dv0.rem[k] <= {sq[qnlerp_pkg::SqrtSteps-1].mag[k], 14'b0}
                      + qnlerp_pkg::NumW'(sq[qnlerp_pkg::SqrtSteps-1].root[qnlerp_pkg::RootW-1:1]);
      end
      dv0.quo  <= '0;
      dv0.n    <= sq[qnlerp_pkg::SqrtSteps-1].root;
      dv0.neg  <= sq[qnlerp_pkg::SqrtSteps-1].neg;
      dv0.zero <= sq[qnlerp_pkg::SqrtSteps-1].zero;
    end
  end

  // Restoring divide, one quotient bit per stage in all four lanes
  for (genvar g = 0; g < qnlerp_pkg::DivSteps; g++) begin : g_div
    dv_st_t                     src;
    dv_st_t                     nxt;
    logic [qnlerp_pkg::NumW-1:0] dsr;

    if (g == 0) begin : g_first
      assign src = dv0;
    end else begin : g_rest
      assign src = dv[g-1];
    end

    always_comb begin
      nxt = src;
      dsr = qnlerp_pkg::NumW'(src.n) << (qnlerp_pkg::DivSteps - 1 - g);
      for (int k = 0; k < 4; k++) begin
        if (src.rem[k] >= dsr) begin
          nxt.rem[k] = src.rem[k] - dsr;
          nxt.quo[k][qnlerp_pkg::DivSteps-1-g] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) dv[g] <= nxt;
    end
  end

  // Reapply signs, substitute identity at zero length
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        if (dv[qnlerp_pkg::DivSteps-1].zero) begin
          out_c[k] <= (k == 0) ? qnlerp_pkg::OutBits'(qnlerp_pkg::Q14One) : '0;
        end else if (dv[qnlerp_pkg::DivSteps-1].neg[k]) begin
          out_c[k] <= -qnlerp_pkg::OutBits'(dv[qnlerp_pkg::DivSteps-1].quo[k]);
        end else begin
          out_c[k] <= qnlerp_pkg::OutBits'(dv[qnlerp_pkg::DivSteps-1].quo[k]);
        end
      end
      fallback <= dv[qnlerp_pkg::DivSteps-1].zero;
    end
  end

endmodule

### hw/rtl/quaternion_nlerp_shortest_unit.sv
// Channel   Direction  Fields
// s_*       in         tdata: from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z,
//                      blend_weight
// m_*       out        tdata: out_w, out_x, out_y, out_z; tuser: identity_fallback
//
// One item per cycle while the output is not stalled; the latency is set by the input and
// blend normalizers in series, each with one-bit-per-stage square root and divide chains.
// rst clears only the valid bits of the pipeline.
// A result that waits on m_tready freezes the whole pipeline; s_tready falls
// with it, and nothing is dropped or repeated.
module quaternion_nlerp_shortest_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z, blend_weight, pad
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_w, out_x, out_y, out_z
  output logic [63:0]  m_tdata,
  // identity_fallback
  output logic [0:0]   m_tuser
);

  logic                                  ce;
  logic [qnlerp_pkg::TotLat-1:0]         vld;

  logic signed [qnlerp_pkg::CompBits-1:0] t0_a [4];
  logic signed [qnlerp_pkg::CompBits-1:0] t0_b [4];
  logic [qnlerp_pkg::AlphaBits-1:0]       t0_alpha;
  logic [qnlerp_pkg::AlphaBits-1:0]       in_alpha;
  logic [qnlerp_pkg::AlphaBits-1:0]       a_dly [qnlerp_pkg::NormLat];

  qnlerp_pkg::norm_in_t n0_in [4];
  qnlerp_pkg::norm_in_t n1_in [4];
  qnlerp_pkg::comp_t    q0 [4];
  qnlerp_pkg::comp_t    q1 [4];
  logic                 n0_fb;
  logic                 n1_fb;

  logic signed [31:0]             t1_p [4];
  qnlerp_pkg::comp_t              t1_q0 [4];
  qnlerp_pkg::comp_t              t1_q1 [4];
  logic [qnlerp_pkg::AlphaBits-1:0] t1_alpha;
  logic signed [33:0]             dot;
  qnlerp_pkg::comp_t              t2_q0 [4];
  qnlerp_pkg::comp_t              t2_q1 [4];
  logic [qnlerp_pkg::AlphaBits-1:0] t2_alpha;
  logic [qnlerp_pkg::AlphaBits-1:0] t2_wa;
  logic signed [31:0]             t3_m0 [4];
  logic signed [31:0]             t3_m1 [4];
  logic signed [32:0]             mix_sum [4];
  qnlerp_pkg::norm_in_t           t4_mix [4];
  qnlerp_pkg::comp_t              res [4];
  logic                           res_fb;

  // Advance everything unless a finished result is stalled
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[qnlerp_pkg::TotLat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[qnlerp_pkg::TotLat-2:0], s_tvalid};
    end
  end

  // Register the incoming item, saturate the weight at one
  assign in_alpha = (s_tdata[142:128] > qnlerp_pkg::AlphaBits'(qnlerp_pkg::Q14One))
                    ? qnlerp_pkg::AlphaBits'(qnlerp_pkg::Q14One) : s_tdata[142:128];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        t0_a[k] <= s_tdata[16*k +: 16];
        t0_b[k] <= s_tdata[64 + 16*k +: 16];
      end
      t0_alpha <= in_alpha;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      n0_in[k] = {{(qnlerp_pkg::NormW-qnlerp_pkg::CompBits){t0_a[k][qnlerp_pkg::CompBits-1]}},
                  t0_a[k]};
      n1_in[k] = {{(qnlerp_pkg::NormW-qnlerp_pkg::CompBits){t0_b[k][qnlerp_pkg::CompBits-1]}},
                  t0_b[k]};
    end
  end

  qnlerp_norm u_norm0 (.clk(clk), .ce(ce), .in_c(n0_in), .out_c(q0), .fallback(n0_fb));
  qnlerp_norm u_norm1 (.clk(clk), .ce(ce), .in_c(n1_in), .out_c(q1), .fallback(n1_fb));

  // Carry the weight alongside the input normalizers
  always_ff @(posedge clk) begin
    if (ce) begin
      a_dly[0] <= t0_alpha;
      for (int i = 1; i < qnlerp_pkg::NormLat; i++) a_dly[i] <= a_dly[i-1];
    end
  end

  // Dot product terms
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) t1_p[k] <= q0[k] * q1[k];
      t1_q0    <= q0;
      t1_q1    <= q1;
      t1_alpha <= a_dly[qnlerp_pkg::NormLat-1];
    end
  end

  // Flip the second quaternion onto the shorter arc
  assign dot = 34'(t1_p[0]) + 34'(t1_p[1]) + 34'(t1_p[2]) + 34'(t1_p[3]);

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) t2_q1[k] <= dot[33] ? -t1_q1[k] : t1_q1[k];
      t2_q0    <= t1_q0;
      t2_alpha <= t1_alpha;
      t2_wa    <= qnlerp_pkg::AlphaBits'(qnlerp_pkg::Q14One) - t1_alpha;
    end
  end

  // Weighted terms, then the exact blend
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        t3_m0[k] <= $signed({1'b0, t2_wa}) * t2_q0[k];
        t3_m1[k] <= $signed({1'b0, t2_alpha}) * t2_q1[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) mix_sum[k] = 33'(t3_m0[k]) + 33'(t3_m1[k]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) t4_mix[k] <= mix_sum[k][qnlerp_pkg::NormW-1:0];
    end
  end

  qnlerp_norm u_norm2 (.clk(clk), .ce(ce), .in_c(t4_mix), .out_c(res), .fallback(res_fb));

  assign m_tdata = {res[3], res[2], res[1], res[0]};
  assign m_tuser = res_fb;

endmodule

### sim/quaternion_nlerp_shortest_unit_tb.sv
`timescale 1ns / 1ps

module quaternion_nlerp_shortest_unit_tb;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic identity_fallback;
  } blend_out_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z, blend_weight, pad
  logic [143:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // out_w, out_x, out_y, out_z
  logic [63:0]  m_tdata;
  // identity_fallback
  logic [0:0]   m_tuser;

  logic [143:0] pair_queue[$];
  blend_out_t   expected_blends[$];
  int           send_idle_pct;
  int           recv_idle_pct;
  int           errors;
  int           cycle_count;
  logic         s_tready_seen;

  quaternion_nlerp_shortest_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Integer square root, floor
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale to unit length in Q14; returns 1 when identity is substituted
  function automatic bit to_unit(input longint q[4], output longint r[4]);
    longint unsigned mag[4];
    bit neg[4];
    longint unsigned top, sum, n;
    top = 0;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      neg[k] = q[k] < 0;
      mag[k] = neg[k] ? -q[k] : q[k];
      if (mag[k] > top) top = mag[k];
    end
    if (top == 0) begin
      r[0] = qnlerp_pkg::Q14One;
      r[1] = 0; r[2] = 0; r[3] = 0;
      return 1'b1;
    end
    while (top >= (64'd1 << 30)) begin
      for (int k = 0; k < 4; k++) mag[k] >>= 1;
      top >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      for (int k = 0; k < 4; k++) mag[k] <<= 1;
      top <<= 1;
    end
    for (int k = 0; k < 4; k++) sum += mag[k] * mag[k];
    n = int_sqrt(sum);
    for (int k = 0; k < 4; k++) begin
      longint m;
      m = longint'((mag[k] * qnlerp_pkg::Q14One + (n >> 1)) / n);
      r[k] = neg[k] ? -m : m;
    end
    return 1'b0;
  endfunction

  function automatic blend_out_t predict_blend(input logic [143:0] d);
    longint a[4], b[4], q0[4], q1[4], mix[4], res[4];
    longint dot, alpha;
    bit fb;
    blend_out_t o;
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      a[k] = longint'($signed(d[16*k +: 16]));
      b[k] = longint'($signed(d[64 + 16*k +: 16]));
    end
    alpha = d[128 +: 15];
    if (alpha > qnlerp_pkg::Q14One) alpha = qnlerp_pkg::Q14One;
    void'(to_unit(a, q0));
    void'(to_unit(b, q1));
    for (int k = 0; k < 4; k++) dot += q0[k] * q1[k];
    // flip the second quaternion onto the shorter arc
    if (dot < 0)
      for (int k = 0; k < 4; k++) q1[k] = -q1[k];
    for (int k = 0; k < 4; k++) begin
      mix[k] = (qnlerp_pkg::Q14One - alpha) * q0[k] + alpha * q1[k];
    end
    fb = to_unit(mix, res);
    o.w = res[0][15:0];
    o.x = res[1][15:0];
    o.y = res[2][15:0];
    o.z = res[3][15:0];
    o.identity_fallback = fb;
    return o;
  endfunction

  function automatic logic [143:0] pack_pair(input logic [15:0] f[4], input logic [15:0] t[4],
                                             input logic [14:0] wgt);
    logic [143:0] d;
    d = '0;
    for (int k = 0; k < 4; k++) begin
      d[16*k +: 16] = f[k];
      d[64 + 16*k +: 16] = t[k];
    end
    d[128 +: 15] = wgt;
    return d;
  endfunction

  // Append an item to the pending queue
  task automatic queue_pair(input logic [143:0] d);
    pair_queue = {pair_queue, d};
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 6)) - 16'd3;
      4: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 15'd0;
      1: return 15'd16384;
      2: return 15'($urandom_range(16385, 32767));
      default: return 15'($urandom_range(0, 16384));
    endcase
  endfunction

  task automatic add_random_pairs(input int count);
    logic [15:0] f[4], t[4];
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 4; k++) begin
        f[k] = rand_comp();
        t[k] = rand_comp();
      end
      // opposite or identical quaternions exercise the zero blend and the flip
      case ($urandom_range(0, 9))
        0: for (int k = 0; k < 4; k++) t[k] = -f[k];
        1: t = f;
        2: for (int k = 0; k < 4; k++) f[k] = 16'($urandom_range(0, 7)) - 16'd3;
        default: ;
      endcase
      queue_pair(pack_pair(f, t, rand_weight()));
    end
  endtask

  task automatic wait_drained();
    while (pair_queue.size() != 0 || s_tvalid || expected_blends.size() != 0) @(posedge clk);
  endtask

  // Driver: present items at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready_seen) begin
      if (pair_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tdata  <= pair_queue.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Record acceptance at the rising edge
  always @(posedge clk) begin
    s_tready_seen <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_blends = {expected_blends, predict_blend(s_tdata)};
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      blend_out_t got, exp_o;
      got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48], m_tuser[0]};
      if (expected_blends.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
      end else begin
        exp_o = expected_blends.pop_front();
        if (got !== exp_o) begin
          $display("%0t: mismatch, expected w=%0d x=%0d y=%0d z=%0d fb=%0b",
                   $time, exp_o.w, exp_o.x, exp_o.y, exp_o.z, exp_o.identity_fallback);
          $display("%0t:           actual w=%0d x=%0d y=%0d z=%0d fb=%0b",
                   $time, got.w, got.x, got.y, got.z, got.identity_fallback);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] f[4], t[4];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 20;
    recv_idle_pct = 66;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero inputs, extremes, opposite pairs, weight ends and saturation
    f = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    t = f;
    queue_pair(pack_pair(f, t, 15'd8192));
    f = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
    t = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    queue_pair(pack_pair(f, t, 15'd0));
    queue_pair(pack_pair(f, t, 15'd16384));
    queue_pair(pack_pair(f, t, 15'h7FFF));
    f = '{16'h4000, 16'h0000, 16'h0000, 16'h0000};
    t = '{16'hC000, 16'h0000, 16'h0000, 16'h0000};
    queue_pair(pack_pair(f, t, 15'd8192));
    t = '{16'h0000, 16'h4000, 16'h0000, 16'h0000};
    queue_pair(pack_pair(f, t, 15'd8192));
    f = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    t = '{16'h0001, 16'hFFFF, 16'h0000, 16'h0000};
    queue_pair(pack_pair(f, t, 15'd4096));
    f = '{16'h0001, 16'h0000, 16'h0000, 16'h0000};
    t = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
    queue_pair(pack_pair(f, t, 15'd16384));
    f = '{16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0};
    t = '{16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F};
    queue_pair(pack_pair(f, t, 15'h2AAA));
    queue_pair(pack_pair(t, f, 15'h5555));
    add_random_pairs(620);
    wait_drained();

    send_idle_pct = 66;
    recv_idle_pct = 20;
    add_random_pairs(630);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_pairs(640);
    wait_drained();
    repeat (qnlerp_pkg::TotLat + 20) @(posedge clk);

    if (errors == 0 && expected_blends.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/qnlerp_pkg.sv
hw/rtl/qnlerp_norm.sv
hw/rtl/quaternion_nlerp_shortest_unit.sv
sim/quaternion_nlerp_shortest_unit_tb.sv
